[hdl/lrl_pkg.sv]
// Shared types and constants for the LRU replacer list.
// Request kind codes, field widths and the result record used by the
// sequencer and the top level. No dependencies.
package lrl_pkg;

   localparam int FRAME_W        = 6;
   localparam int COUNT_W        = 7;
   localparam int MODE_W         = 2;
   localparam int DEF_NUM_FRAMES = 64;

   localparam logic [MODE_W-1:0] MODE_VICTIM = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PIN    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_UNPIN  = 2'd2;

   typedef struct packed {
      logic               victim_found;
      logic [FRAME_W-1:0] victim_frame;
      logic [COUNT_W-1:0] listed_count;
   } lrl_result_type;

endpackage

[hdl/lrl_link_ram.sv]
// Pointer memory of the LRU replacer list: one write and one read port,
// read data registered. Used for both the next and the previous links.
// No package dependencies.
module lrl_link_ram #(
   parameter int DEPTH = 65,
   parameter int WIDTH = 7
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/lrl_seq.sv]
// Request sequencer of the LRU replacer list: clearing pass, pointer reads,
// unlink and head-link write steps, and the listed frame count.
// Depends on lrl_pkg; drives two lrl_link_ram instances.
module lrl_seq #(
   parameter int NUM_FRAMES = lrl_pkg::DEF_NUM_FRAMES,
   parameter int PW         = $clog2(NUM_FRAMES + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   // request side
   input  logic                        req_valid,
   input  logic [lrl_pkg::MODE_W-1:0]  req_mode,
   input  logic [lrl_pkg::FRAME_W-1:0] req_frame,
   output logic                        req_ready,
   // result side
   output logic                        result_valid,
   output lrl_pkg::lrl_result_type     result,
   input  logic                        result_load,
   // next-link memory
   output logic                        nxt_wr_en,
   output logic [PW-1:0]               nxt_wr_addr,
   output logic [PW-1:0]               nxt_wr_data,
   output logic [PW-1:0]               nxt_rd_addr,
   input  logic [PW-1:0]               nxt_rd_data,
   // previous-link memory
   output logic                        prv_wr_en,
   output logic [PW-1:0]               prv_wr_addr,
   output logic [PW-1:0]               prv_wr_data,
   output logic [PW-1:0]               prv_rd_addr,
   input  logic [PW-1:0]               prv_rd_data
);

   localparam logic [3:0] ST_CLEAR   = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_READ1   = 4'd2;
   localparam logic [3:0] ST_READ2   = 4'd3;
   localparam logic [3:0] ST_UNLINK1 = 4'd4;
   localparam logic [3:0] ST_UNLINK2 = 4'd5;
   localparam logic [3:0] ST_LINK1   = 4'd6;
   localparam logic [3:0] ST_LINK2   = 4'd7;
   localparam logic [3:0] ST_DONE    = 4'd8;

   localparam logic [PW-1:0] SENT = PW'(NUM_FRAMES);

   logic [3:0]                 state_ff, state_in;
   logic [PW-1:0]              clr_ff, clr_in;
   logic [PW-1:0]              count_ff, count_in;
   logic [lrl_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [PW-1:0]              tgt_ff, tgt_in;
   logic [PW-1:0]              lnk_n_ff, lnk_n_in;
   logic [PW-1:0]              lnk_p_ff, lnk_p_in;
   logic                       found_ff, found_in;

   logic                       accept;
   logic [PW+5:0]              frm_ext;
   logic [PW-1:0]              frm_ptr;
   logic                       frm_in_range;
   logic [PW+6:0]              cnt_ext;
   logic [PW+5:0]              tgt_ext;

   assign req_ready    = (state_ff == ST_IDLE);
   assign accept       = req_valid && req_ready;
   assign frm_ext      = {{PW{1'b0}}, req_frame};
   assign frm_ptr      = frm_ext[PW-1:0];
   assign frm_in_range = (frm_ext < (PW+6)'(NUM_FRAMES));
   assign cnt_ext      = {7'd0, count_ff};
   assign tgt_ext      = {6'd0, tgt_ff};

   assign result_valid        = (state_ff == ST_DONE);
   assign result.victim_found = found_ff;
   assign result.victim_frame = found_ff ? tgt_ext[lrl_pkg::FRAME_W-1:0]
                                         : '0;
   assign result.listed_count = cnt_ext[lrl_pkg::COUNT_W-1:0];

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      count_in    = count_ff;
      mode_in     = mode_ff;
      tgt_in      = tgt_ff;
      lnk_n_in    = lnk_n_ff;
      lnk_p_in    = lnk_p_ff;
      found_in    = found_ff;
      nxt_wr_en   = 1'b0;
      nxt_wr_addr = tgt_ff;
      nxt_wr_data = tgt_ff;
      nxt_rd_addr = tgt_ff;
      prv_wr_en   = 1'b0;
      prv_wr_addr = tgt_ff;
      prv_wr_data = tgt_ff;
      prv_rd_addr = tgt_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            // every node points to itself: nothing listed
            nxt_wr_en   = 1'b1;
            nxt_wr_addr = clr_ff;
            nxt_wr_data = clr_ff;
            prv_wr_en   = 1'b1;
            prv_wr_addr = clr_ff;
            prv_wr_data = clr_ff;
            if (clr_ff == SENT) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            nxt_rd_addr = frm_ptr;
            prv_rd_addr = frm_ptr;
            if (req_mode == lrl_pkg::MODE_VICTIM) begin
               prv_rd_addr = SENT;
            end
            if (accept) begin
               mode_in  = req_mode;
               tgt_in   = frm_ptr;
               found_in = 1'b0;
               priority case (1'b1)
                  (req_mode == lrl_pkg::MODE_VICTIM): begin
                     state_in = (count_ff != '0) ? ST_READ1 : ST_DONE;
                  end
                  (req_mode == lrl_pkg::MODE_PIN) ||
                  (req_mode == lrl_pkg::MODE_UNPIN): begin
                     state_in = frm_in_range ? ST_READ1 : ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_READ1: begin
            priority case (1'b1)
               (mode_ff == lrl_pkg::MODE_VICTIM): begin
                  // tail frame is the sentinel's predecessor
                  nxt_rd_addr = prv_rd_data;
                  prv_rd_addr = prv_rd_data;
                  tgt_in      = prv_rd_data;
                  state_in    = (prv_rd_data < SENT) ? ST_READ2 : ST_DONE;
               end
               (mode_ff == lrl_pkg::MODE_PIN): begin
                  lnk_n_in = nxt_rd_data;
                  lnk_p_in = prv_rd_data;
                  state_in = (nxt_rd_data != tgt_ff) ? ST_UNLINK1 : ST_DONE;
               end
               default: begin
                  // unpin: only an unlisted frame goes to the head
                  nxt_rd_addr = SENT;
                  state_in    = (nxt_rd_data == tgt_ff) ? ST_READ2 : ST_DONE;
               end
            endcase
         end
         ST_READ2: begin
            if (mode_ff == lrl_pkg::MODE_VICTIM) begin
               lnk_n_in = nxt_rd_data;
               lnk_p_in = prv_rd_data;
               found_in = 1'b1;
               state_in = ST_UNLINK1;
            end else begin
               lnk_n_in = nxt_rd_data;
               state_in = ST_LINK1;
            end
         end
         ST_UNLINK1: begin
            nxt_wr_en   = 1'b1;
            nxt_wr_addr = lnk_p_ff;
            nxt_wr_data = lnk_n_ff;
            prv_wr_en   = 1'b1;
            prv_wr_addr = lnk_n_ff;
            prv_wr_data = lnk_p_ff;
            state_in    = ST_UNLINK2;
         end
         ST_UNLINK2: begin
            nxt_wr_en = 1'b1;
            prv_wr_en = 1'b1;
            if (count_ff != '0) begin
               count_in = count_ff - 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_LINK1: begin
            nxt_wr_en   = 1'b1;
            nxt_wr_data = lnk_n_ff;
            prv_wr_en   = 1'b1;
            prv_wr_data = SENT;
            state_in    = ST_LINK2;
         end
         ST_LINK2: begin
            nxt_wr_en   = 1'b1;
            nxt_wr_addr = SENT;
            prv_wr_en   = 1'b1;
            prv_wr_addr = lnk_n_ff;
            count_in    = count_ff + 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (result_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         count_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         count_ff <= count_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      tgt_ff   <= tgt_in;
      lnk_n_ff <= lnk_n_in;
      lnk_p_ff <= lnk_p_in;
   end

endmodule

[hdl/lru_replacer_list_top.sv]
// Top level of the LRU replacer list: stream ports and result register.
// Depends on lrl_pkg, lrl_seq and lrl_link_ram.
//
// LRU replacement policy for a pool of NUM_FRAMES frames. Evictable frames
// sit in a circular doubly linked list held in two pointer memories (next
// and previous link) with one sentinel node at index NUM_FRAMES. Each
// request is victim, pin or unpin (req_tuser) on a frame (req_tdata);
// every request returns one response with the found flag, the evicted
// frame and the listed count. After reset the block runs a clearing pass
// over all NUM_FRAMES+1 nodes, one node per cycle, and holds req_tready
// low until it ends. One request is in flight at a time: a victim or
// unpin that changes the list walks the READ1 and READ2 steps and then
// the unlink or link steps, a pin that removes a frame walks READ1 and
// then the unlink steps, and a request that changes nothing skips the
// write steps. The sequence is set by the single read and write port of
// each pointer memory. The result register lets a new request be taken
// while the previous response still waits on rsp_tready.
module lru_replacer_list_top #(
   parameter int NUM_FRAMES = lrl_pkg::DEF_NUM_FRAMES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [5:0] frame, [7:6] zero
   input  logic [1:0]  req_tuser,   // [1:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [5:0] victim_frame, [12:6] listed_count,
                                    // [15:13] zero
   output logic        rsp_tuser    // [0] victim_found
);

   localparam int PW    = $clog2(NUM_FRAMES + 1);
   localparam int DEPTH = NUM_FRAMES + 1;

   logic                    rsp_valid_ff, rsp_valid_in;
   lrl_pkg::lrl_result_type rsp_ff, rsp_in;
   logic                    result_valid;
   lrl_pkg::lrl_result_type result;
   logic                    result_load;

   logic          nxt_wr_en, prv_wr_en;
   logic [PW-1:0] nxt_wr_addr, nxt_wr_data, nxt_rd_addr, nxt_rd_data;
   logic [PW-1:0] prv_wr_addr, prv_wr_data, prv_rd_addr, prv_rd_data;

   lrl_seq #(
      .NUM_FRAMES (NUM_FRAMES),
      .PW         (PW)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_mode     (req_tuser),
      .req_frame    (req_tdata[5:0]),
      .req_ready    (req_tready),
      .result_valid (result_valid),
      .result       (result),
      .result_load  (result_load),
      .nxt_wr_en    (nxt_wr_en),
      .nxt_wr_addr  (nxt_wr_addr),
      .nxt_wr_data  (nxt_wr_data),
      .nxt_rd_addr  (nxt_rd_addr),
      .nxt_rd_data  (nxt_rd_data),
      .prv_wr_en    (prv_wr_en),
      .prv_wr_addr  (prv_wr_addr),
      .prv_wr_data  (prv_wr_data),
      .prv_rd_addr  (prv_rd_addr),
      .prv_rd_data  (prv_rd_data)
   );

   lrl_link_ram #(
      .DEPTH (DEPTH),
      .WIDTH (PW)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (nxt_wr_en),
      .wr_addr (nxt_wr_addr),
      .wr_data (nxt_wr_data),
      .rd_addr (nxt_rd_addr),
      .rd_data (nxt_rd_data)
   );

   lrl_link_ram #(
      .DEPTH (DEPTH),
      .WIDTH (PW)
   ) u_prev_ram (
      .clock   (clock),
      .wr_en   (prv_wr_en),
      .wr_addr (prv_wr_addr),
      .wr_data (prv_wr_data),
      .rd_addr (prv_rd_addr),
      .rd_data (prv_rd_data)
   );

   // take a finished result whenever the output slot is empty or draining
   assign result_load = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (result_load) begin
         rsp_valid_in = result_valid;
         if (result_valid) begin
            rsp_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.victim_found;
   assign rsp_tdata  = {3'd0, rsp_ff.listed_count, rsp_ff.victim_frame};

endmodule

[hdl/lrl_checker.sv]
// Port-level checks for the LRU replacer list, bound to the top level.
// Depends on lru_replacer_list_top's port list only.
module lrl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser
);

   // no response comes out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // one request in flight: ready drops after each acceptance
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted on back-to-back cycles");

   // a response without a victim carries frame zero and no stray bits
   a_no_victim_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:13] == 3'd0) &&
                     (rsp_tuser || (rsp_tdata[5:0] == 6'd0)))
      else $error("malformed response payload");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

endmodule

bind lru_replacer_list_top lrl_checker u_lrl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
